// ===== rtl/core/tcg_pkg.sv =====
// tcg_pkg: widths, register indexes, reset values and shared types for the
// tone curve table generator; no dependencies, used by tone_curve_table_generator
package tcg_pkg;

	localparam int XW   = 10;   // control point and index width
	localparam int YW   = 8;    // level width
	localparam int SW   = 11;   // table size register width
	localparam int CIW  = 3;    // config register index width
	localparam int CDW  = 11;   // config write data width
	localparam int PW   = 22;   // signed width of squared terms and divisor
	localparam int DW   = 21;   // magnitude width of divisor
	localparam int NW   = 32;   // signed width of numerator
	localparam int QB   = 8;    // quotient bits

	localparam int MAX_TABLE_SIZE_DEF = 1024;
	localparam logic [YW-1:0] LEVEL_MAX = 8'd255;

	localparam logic [XW-1:0] RST_P1X = 10'd0;
	localparam logic [YW-1:0] RST_P1Y = 8'd0;
	localparam logic [XW-1:0] RST_P2X = 10'd128;
	localparam logic [YW-1:0] RST_P2Y = 8'd128;
	localparam logic [XW-1:0] RST_P3X = 10'd255;
	localparam logic [YW-1:0] RST_P3Y = 8'd255;
	localparam logic          RST_LIN = 1'b0;
	localparam logic [SW-1:0] RST_SIZE = 11'd256;

	typedef enum logic [CIW-1:0] {
		CFG_P1X  = 3'd0,
		CFG_P1Y  = 3'd1,
		CFG_P2X  = 3'd2,
		CFG_P2Y  = 3'd3,
		CFG_P3X  = 3'd4,
		CFG_P3Y  = 3'd5,
		CFG_LIN  = 3'd6,
		CFG_SIZE = 3'd7
	} cfg_idx_t;

	// result status that rides along the arithmetic stages
	typedef struct packed {
		logic          oor;
		logic          fixed;
		logic [YW-1:0] y;
	} tag_t;

	// one stage of the restoring divider
	typedef struct packed {
		logic            oor;
		logic            fixed;
		logic [YW-1:0]   y;
		logic [NW-2:0]   rem;
		logic [DW-1:0]   den;
	} dv_t;

	function automatic logic signed [XW:0] sdiff(input logic [XW-1:0] a,
		input logic [XW-1:0] b);
		sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

endpackage

// ===== rtl/core/tone_curve_table_generator.sv =====
// tone_curve_table_generator: three point tone curve level per table index
// depends on tcg_pkg
//
// usage: the config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the control points, linear_mode and table_size; it is always ready. the user
// must write it only while no transaction is in flight; the block does not
// enforce this. the input channel (in_valid/in_ready) takes one table_index per
// transaction; the output channel (out_valid/out_ready) returns level = 255 - y
// and out_of_range. five stages form the squared terms, products and the signed
// numerator, one stage sorts out saturation, eight stages each resolve one
// quotient bit of the divider. throughput is one transaction per cycle while
// the receiver does not stall, set by the one-bit-per-stage divider pipeline.
// when the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing is lost or repeated. reset clears the valid bits and loads the
// register defaults (points (0,0),(128,128),(255,255), quadratic mode, table
// size 256).
module tone_curve_table_generator #(
	parameter int MAX_TABLE_SIZE = tcg_pkg::MAX_TABLE_SIZE_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [tcg_pkg::CIW-1:0]  cfg_index,
	input  logic [tcg_pkg::CDW-1:0]  cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [tcg_pkg::XW-1:0]   table_index,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [tcg_pkg::YW-1:0]   level,
	output logic                     out_of_range
);

	localparam int XW = tcg_pkg::XW;
	localparam int YW = tcg_pkg::YW;
	localparam int SW = tcg_pkg::SW;
	localparam int PW = tcg_pkg::PW;
	localparam int DW = tcg_pkg::DW;
	localparam int NW = tcg_pkg::NW;
	localparam int QB = tcg_pkg::QB;
	localparam int MW = $clog2(MAX_TABLE_SIZE + 1);
	localparam int EW = (SW > MW) ? SW : MW;
	localparam logic [EW-1:0] MAX_E = EW'(MAX_TABLE_SIZE);

	// configuration registers
	logic [XW-1:0] p1x_q, p2x_q, p3x_q;
	logic [YW-1:0] p1y_q, p2y_q, p3y_q;
	logic          lin_q;
	logic [SW-1:0] size_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1x_q  <= tcg_pkg::RST_P1X;
			p1y_q  <= tcg_pkg::RST_P1Y;
			p2x_q  <= tcg_pkg::RST_P2X;
			p2y_q  <= tcg_pkg::RST_P2Y;
			p3x_q  <= tcg_pkg::RST_P3X;
			p3y_q  <= tcg_pkg::RST_P3Y;
			lin_q  <= tcg_pkg::RST_LIN;
			size_q <= tcg_pkg::RST_SIZE;
		end else if (cfg_valid && cfg_ready) begin
			case (tcg_pkg::cfg_idx_t'(cfg_index))
				tcg_pkg::CFG_P1X:  p1x_q  <= cfg_data[XW-1:0];
				tcg_pkg::CFG_P1Y:  p1y_q  <= cfg_data[YW-1:0];
				tcg_pkg::CFG_P2X:  p2x_q  <= cfg_data[XW-1:0];
				tcg_pkg::CFG_P2Y:  p2y_q  <= cfg_data[YW-1:0];
				tcg_pkg::CFG_P3X:  p3x_q  <= cfg_data[XW-1:0];
				tcg_pkg::CFG_P3Y:  p3y_q  <= cfg_data[YW-1:0];
				tcg_pkg::CFG_LIN:  lin_q  <= cfg_data[0];
				tcg_pkg::CFG_SIZE: size_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// effective size and clamped points
	logic [EW-1:0] size_e, lim_e;
	logic [XW-1:0] x1, x2, x3;

	always_comb begin
		size_e = (EW'(size_q) > MAX_E) ? MAX_E : EW'(size_q);
		lim_e  = size_e - EW'(1);
		x1 = p1x_q;
		x2 = p2x_q;
		x3 = p3x_q;
		if (size_e != '0) begin
			if (EW'(p1x_q) > lim_e) x1 = lim_e[XW-1:0];
			if (EW'(p2x_q) > lim_e) x2 = lim_e[XW-1:0];
			if (EW'(p3x_q) > lim_e) x3 = lim_e[XW-1:0];
		end
	end

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [QB:0] dv_vld;
	tcg_pkg::dv_t dv_s [QB+1];

	assign adv      = !dv_vld[QB] || out_ready;
	assign in_ready = adv;

	// stage 1: segment selection and operands
	tcg_pkg::tag_t          tag_c;
	logic                   seg2_c;
	logic [XW-1:0]          xe_c;
	logic signed [XW:0]     ta_c, tb_c, tc_c, da_c, db_c;
	logic signed [YW:0]     dy_c;
	logic [YW-1:0]          base_c;

	always_comb begin
		tag_c.oor   = EW'(table_index) >= size_e;
		tag_c.fixed = 1'b0;
		tag_c.y     = p1y_q;
		seg2_c      = 1'b0;
		xe_c        = table_index;
		if (table_index >= x3) begin
			if (x2 < x3) begin
				seg2_c = 1'b1;
				xe_c   = x3 - XW'(1);
			end else if (x1 < x2) begin
				xe_c = x2 - XW'(1);
			end else begin
				tag_c.fixed = 1'b1;
			end
		end else if (table_index >= x2) begin
			seg2_c = 1'b1;
		end else if (table_index < x1) begin
			tag_c.fixed = 1'b1;
		end
		if (seg2_c && !lin_q && x1 == x2 && !tag_c.fixed) begin
			tag_c.fixed = 1'b1;
			tag_c.y     = p2y_q;
		end
		if (lin_q) begin
			tc_c = (XW+1)'(1);
			tb_c = '0;
			db_c = (XW+1)'(1);
			if (seg2_c) begin
				ta_c   = tcg_pkg::sdiff(xe_c, x2);
				da_c   = tcg_pkg::sdiff(x3, x2);
				dy_c   = $signed({1'b0, p3y_q}) - $signed({1'b0, p2y_q});
				base_c = p2y_q;
			end else begin
				ta_c   = tcg_pkg::sdiff(xe_c, x1);
				da_c   = tcg_pkg::sdiff(x2, x1);
				dy_c   = $signed({1'b0, p2y_q}) - $signed({1'b0, p1y_q});
				base_c = p1y_q;
			end
		end else begin
			dy_c = $signed({1'b0, p2y_q}) - $signed({1'b0, p1y_q});
			da_c = tcg_pkg::sdiff(x2, x1);
			if (seg2_c) begin
				ta_c   = tcg_pkg::sdiff(xe_c, x3);
				tb_c   = tcg_pkg::sdiff(x2, x3);
				db_c   = tcg_pkg::sdiff(x2, x3);
				base_c = p2y_q;
			end else begin
				ta_c   = tcg_pkg::sdiff(xe_c, x1);
				tb_c   = '0;
				db_c   = tcg_pkg::sdiff(x2, x1);
				base_c = p1y_q;
			end
			tc_c = ta_c;
		end
	end

	tcg_pkg::tag_t          tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic signed [XW:0]     ta_s1, tb_s1, tc_s1, da_s1, db_s1;
	logic signed [YW:0]     dy_s1, dy_s2, dy_s3;
	logic [YW-1:0]          base_s1, base_s2, base_s3, base_s4;
	logic signed [PW-1:0]   pa_s2, pb_s2, dd_s2, u_s3, d_s3, d_s4;
	logic signed [NW-1:0]   m1_s4, m2_s4, n_s5;
	logic [DW-1:0]          den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 2 to 5 arithmetic
	logic signed [PW-1:0] ta_e, tb_e, tc_e, da_e, db_e;
	logic signed [NW-1:0] dy_e, u_e, base_e, d_e, sum_c;
	logic                 dneg_c;
	tcg_pkg::tag_t        tag_z;

	always_comb begin
		ta_e   = PW'(ta_s1);
		tb_e   = PW'(tb_s1);
		tc_e   = PW'(tc_s1);
		da_e   = PW'(da_s1);
		db_e   = PW'(db_s1);
		dy_e   = NW'(dy_s3);
		u_e    = NW'(u_s3);
		base_e = $signed({{(NW-YW){1'b0}}, base_s3});
		d_e    = NW'(d_s3);
		dneg_c = d_s4[PW-1];
		sum_c  = dneg_c ? (-m1_s4 - m2_s4) : (m1_s4 + m2_s4);
		tag_z  = tag_s4;
		if (d_s4 == '0 && !tag_s4.fixed) begin
			tag_z.fixed = 1'b1;
			tag_z.y     = base_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= tag_c;
			ta_s1   <= ta_c;
			tb_s1   <= tb_c;
			tc_s1   <= tc_c;
			da_s1   <= da_c;
			db_s1   <= db_c;
			dy_s1   <= dy_c;
			base_s1 <= base_c;

			tag_s2  <= tag_s1;
			pa_s2   <= ta_e * tc_e;
			pb_s2   <= tb_e * tb_e;
			dd_s2   <= da_e * db_e;
			dy_s2   <= dy_s1;
			base_s2 <= base_s1;

			tag_s3  <= tag_s2;
			u_s3    <= pa_s2 - pb_s2;
			d_s3    <= dd_s2;
			dy_s3   <= dy_s2;
			base_s3 <= base_s2;

			tag_s4  <= tag_s3;
			m1_s4   <= dy_e * u_e;
			m2_s4   <= base_e * d_e;
			d_s4    <= d_s3;
			base_s4 <= base_s3;

			tag_s5 <= tag_z;
			n_s5   <= sum_c;
			den_s5 <= DW'(dneg_c ? -d_s4 : d_s4);
		end
	end

	// stage 6: sign and saturation, then one quotient bit per stage
	tcg_pkg::dv_t dv_c [QB+1];

	always_comb begin
		dv_c[0].oor   = tag_s5.oor;
		dv_c[0].fixed = tag_s5.fixed;
		dv_c[0].y     = tag_s5.y;
		dv_c[0].rem   = n_s5[NW-2:0];
		dv_c[0].den   = den_s5;
		if (!tag_s5.fixed) begin
			if (n_s5[NW-1]) begin
				dv_c[0].fixed = 1'b1;
				dv_c[0].y     = '0;
			end else if (n_s5[NW-2:0] >= ((NW-1)'(den_s5) << QB)) begin
				dv_c[0].fixed = 1'b1;
				dv_c[0].y     = tcg_pkg::LEVEL_MAX;
			end else begin
				dv_c[0].y = '0;
			end
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [NW-2:0] sh;
		always_comb begin
			sh       = (NW-1)'(dv_s[k-1].den) << (QB - k);
			dv_c[k]  = dv_s[k-1];
			if (!dv_s[k-1].fixed && dv_s[k-1].rem >= sh) begin
				dv_c[k].rem       = dv_s[k-1].rem - sh;
				dv_c[k].y[QB - k] = 1'b1;
			end
		end
	end

	for (genvar k = 0; k <= QB; k++) begin : g_dvreg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[k] <= 1'b0;
			end else if (adv) begin
				dv_vld[k] <= (k == 0) ? vld_s5 : dv_vld[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k] <= dv_c[k];
			end
		end
	end

	assign out_valid    = dv_vld[QB];
	assign out_of_range = dv_s[QB].oor;
	assign level        = dv_s[QB].oor ? '0 : ~dv_s[QB].y;

	a_oor_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> level == '0)
		else $error("out of range result with nonzero level");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow pipeline advance");

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dv_s[QB].fixed |-> dv_s[QB].rem < (NW-1)'(dv_s[QB].den))
		else $error("divider remainder not below divisor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s5) && $stable(dv_vld))
		else $error("pipeline moved while stalled");

endmodule

// ===== tb/tcg_checker.sv =====
// tcg_checker: watches the config, table index and result channels of the tone
// curve table generator, predicts each level and compares; depends on tcg_pkg
`timescale 1ns / 1ps
module tcg_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [tcg_pkg::CIW-1:0] cfg_index,
	input  logic [tcg_pkg::CDW-1:0] cfg_data,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [tcg_pkg::XW-1:0]  table_index,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [tcg_pkg::YW-1:0]  level,
	input  logic                    out_of_range,
	output int                      fail_count,
	output int                      pending
);

	typedef struct packed {
		logic [tcg_pkg::YW-1:0] lvl;
		logic                   oor;
	} curve_result_t;

	logic [tcg_pkg::XW-1:0] p1x, p2x, p3x;
	logic [tcg_pkg::YW-1:0] p1y, p2y, p3y;
	logic                   lin;
	logic [tcg_pkg::SW-1:0] tsize;
	curve_result_t expected_levels[$];

	function automatic longint div_or(longint n, longint d, longint fb);
		if (d == 0) return fb;
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		return n / d;
	endfunction

	function automatic longint clamp_level(longint v);
		if (v < 0) return 0;
		if (v > 255) return 255;
		return v;
	endfunction

	function automatic longint first_segment(longint x, longint x1, longint x2,
		longint y1, longint y2);
		longint d;
		d = x2 - x1;
		if (lin) return clamp_level(div_or((y2 - y1) * (x - x1) + y1 * d, d, y1));
		return clamp_level(div_or((y2 - y1) * (x - x1) * (x - x1) + y1 * d * d,
			d * d, y1));
	endfunction

	function automatic longint second_segment(longint x, longint x1, longint x2,
		longint x3, longint y1, longint y2, longint y3);
		longint d;
		if (lin) begin
			d = x3 - x2;
			return clamp_level(div_or((y3 - y2) * (x - x2) + y2 * d, d, y2));
		end
		if (x1 == x2) return y2;
		d = (x2 - x1) * (x2 - x3);
		return clamp_level(div_or((y2 - y1) * ((x - x3) * (x - x3)
			- (x2 - x3) * (x2 - x3)) + y2 * d, d, y2));
	endfunction

	function automatic curve_result_t predict_level(logic [tcg_pkg::XW-1:0] ti);
		curve_result_t r;
		longint sz, idx, x1, x2, x3, y;
		sz = tsize;
		idx = ti;
		if (sz > tcg_pkg::MAX_TABLE_SIZE_DEF) sz = tcg_pkg::MAX_TABLE_SIZE_DEF;
		if (idx >= sz) begin
			r.lvl = '0;
			r.oor = 1'b1;
			return r;
		end
		x1 = (p1x > sz - 1) ? sz - 1 : p1x;
		x2 = (p2x > sz - 1) ? sz - 1 : p2x;
		x3 = (p3x > sz - 1) ? sz - 1 : p3x;
		if (idx >= x3) begin
			if (x2 < x3) y = second_segment(x3 - 1, x1, x2, x3, p1y, p2y, p3y);
			else if (x1 < x2) y = first_segment(x2 - 1, x1, x2, p1y, p2y);
			else y = p1y;
		end else if (idx >= x2) y = second_segment(idx, x1, x2, x3, p1y, p2y, p3y);
		else if (idx >= x1) y = first_segment(idx, x1, x2, p1y, p2y);
		else y = p1y;
		r.lvl = 8'(255 - y);
		r.oor = 1'b0;
		return r;
	endfunction

	assign pending = expected_levels.size();

	always_ff @(posedge clk or negedge arst_n) begin
		curve_result_t e;
		int nf;
		nf = 0;
		if (!arst_n) begin
			p1x <= tcg_pkg::RST_P1X; p1y <= tcg_pkg::RST_P1Y;
			p2x <= tcg_pkg::RST_P2X; p2y <= tcg_pkg::RST_P2Y;
			p3x <= tcg_pkg::RST_P3X; p3y <= tcg_pkg::RST_P3Y;
			lin <= tcg_pkg::RST_LIN; tsize <= tcg_pkg::RST_SIZE;
			fail_count <= 0;
			expected_levels.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (tcg_pkg::cfg_idx_t'(cfg_index))
					tcg_pkg::CFG_P1X: p1x <= cfg_data[tcg_pkg::XW-1:0];
					tcg_pkg::CFG_P1Y: p1y <= cfg_data[tcg_pkg::YW-1:0];
					tcg_pkg::CFG_P2X: p2x <= cfg_data[tcg_pkg::XW-1:0];
					tcg_pkg::CFG_P2Y: p2y <= cfg_data[tcg_pkg::YW-1:0];
					tcg_pkg::CFG_P3X: p3x <= cfg_data[tcg_pkg::XW-1:0];
					tcg_pkg::CFG_P3Y: p3y <= cfg_data[tcg_pkg::YW-1:0];
					tcg_pkg::CFG_LIN: lin <= cfg_data[0];
					tcg_pkg::CFG_SIZE: tsize <= cfg_data[tcg_pkg::SW-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) expected_levels.push_back(predict_level(table_index));
			if (out_valid && out_ready) begin
				if (expected_levels.size() == 0) begin
					$error("result transaction with none expected");
					nf = nf + 1;
				end else begin
					e = expected_levels.pop_front();
					if (level !== e.lvl) begin
						$error("level: expected %0d, actual %0d", e.lvl, level);
						nf = nf + 1;
					end
					if (out_of_range !== e.oor) begin
						$error("out_of_range: expected %0d, actual %0d", e.oor,
							out_of_range);
						nf = nf + 1;
					end
				end
			end
			if (nf != 0) fail_count <= fail_count + nf;
		end
	end
endmodule

// ===== tb/tb_tone_curve_table_generator.sv =====
// tb_tone_curve_table_generator: drives configuration phases and table index
// transactions into the block; depends on tcg_pkg and tcg_checker
`timescale 1ns / 1ps
module tb_tone_curve_table_generator;

	logic                    clk, arst_n;
	logic                    cfg_valid, cfg_ready;
	logic [tcg_pkg::CIW-1:0] cfg_index;
	logic [tcg_pkg::CDW-1:0] cfg_data;
	logic                    in_valid, in_ready;
	logic [tcg_pkg::XW-1:0]  table_index;
	logic                    out_valid, out_ready;
	logic [tcg_pkg::YW-1:0]  level;
	logic                    out_of_range;
	int                      fail_count, pending;
	bit                      calm;

	tone_curve_table_generator DUT (.*);
	tcg_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 7);

	task automatic write_reg(tcg_pkg::cfg_idx_t idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= tcg_pkg::CDW'(value);
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic send_index(int value);
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		table_index <= tcg_pkg::XW'(value);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_curve(int ax, int ay, int bx, int by, int cx, int cy,
		int lm, int sz);
		write_reg(tcg_pkg::CFG_P1X, ax); write_reg(tcg_pkg::CFG_P1Y, ay);
		write_reg(tcg_pkg::CFG_P2X, bx); write_reg(tcg_pkg::CFG_P2Y, by);
		write_reg(tcg_pkg::CFG_P3X, cx); write_reg(tcg_pkg::CFG_P3Y, cy);
		write_reg(tcg_pkg::CFG_LIN, lm); write_reg(tcg_pkg::CFG_SIZE, sz);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_curve;
		int sz;
		case ($urandom_range(5))
			0: sz = 1024;
			1: sz = $urandom_range(2047, 1025);
			2: sz = $urandom_range(4);
			default: sz = $urandom_range(300, 2);
		endcase
		if ($urandom_range(3) == 0)
			set_curve($urandom_range(1023), $urandom_range(255), $urandom_range(1023),
				$urandom_range(255), $urandom_range(1023), $urandom_range(255),
				$urandom_range(1), sz);
		else begin
			int a, b, c;
			a = $urandom_range(sz > 1 ? sz - 1 : 0);
			b = $urandom_range(sz > 1 ? sz - 1 : 0, a);
			c = $urandom_range(sz > 1 ? sz - 1 : 0, b);
			set_curve(a, $urandom_range(255), b, $urandom_range(255), c,
				$urandom_range(255), $urandom_range(1), sz);
		end
	endtask

	initial begin
		int pts[$];
		arst_n = 0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; table_index = '0; out_ready = 0; calm = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// reset curve, index extremes
		pts = '{0, 1, 127, 128, 200, 254, 255, 256, 1023};
		foreach (pts[i]) send_index(pts[i]);
		drain();
		// coincident first points, quadratic, oversize table
		set_curve(100, 255, 100, 10, 900, 0, 0, 2047);
		pts = '{99, 100, 500, 900, 1023};
		foreach (pts[i]) send_index(pts[i]);
		drain();
		// all points at one x, linear, tiny table
		set_curve(5, 77, 5, 200, 5, 9, 1, 1);
		send_index(0); send_index(1);
		drain();
		// zero size: nothing in range
		set_curve(1023, 0, 1023, 255, 1023, 255, 1, 0);
		send_index(0); send_index(1023);
		drain();
		// descending points exercise saturation
		set_curve(800, 0, 300, 255, 10, 128, 0, 1024);
		pts = '{0, 9, 10, 299, 300, 799, 800, 1023};
		foreach (pts[i]) send_index(pts[i]);
		drain();
		for (int ph = 0; ph < 25; ph++) begin
			random_curve();
			calm = (ph == 12);
			for (int k = 0; k < 50; k++)
				send_index(($urandom_range(3) == 0) ? $urandom_range(1023)
					: $urandom_range(300));
			drain();
		end
		calm = 0;
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/tcg_pkg.sv
rtl/core/tone_curve_table_generator.sv
tb/tcg_checker.sv
tb/tb_tone_curve_table_generator.sv
